>>> rtl/sntbl_pkg.sv
// Package: request, response and table entry types, status codes, controller states.
`timescale 1ns / 1ps

package sntbl_pkg;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_LOOKUP = 1'b1;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_DUP  = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	typedef struct packed {
		logic        opcode;
		logic [63:0] key;
		logic [15:0] entry_size;
		logic [15:0] entry_offset;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic        found;
		logic [6:0]  slot;
		logic [15:0] size_out;
		logic [15:0] offset_out;
	} rsp_t;

	typedef struct packed {
		logic [63:0] key;
		logic [15:0] size;
		logic [15:0] offset;
	} entry_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SEARCH,
		S_CMP,
		S_HIT,
		S_DECIDE,
		S_SHIFT
	} state_t;

endpackage

>>> rtl/sntbl_ram.sv
// Entry memory: one write port, one read port, registered read data.
`timescale 1ns / 1ps

module sntbl_ram #(
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  sntbl_pkg::entry_t        wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output sntbl_pkg::entry_t        rdata
);
	import sntbl_pkg::*;

	entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

>>> rtl/sorted_name_table_insert_lookup_unit.sv
// Top level: sorted key table with binary-search insert and lookup.
//
//   channel   ports                 handshake
//   request   start, busy, req      taken at a clock edge with start high, busy low
//   response  done, rsp             done high for one cycle; no back pressure
//
// Lookup: a binary search, each probe reading the middle entry in S_SEARCH
// and comparing it in S_CMP; log2(CAPACITY) + 1 probes on a full table; then
// S_HIT reads the entry at the final slot, if any, and S_DECIDE responds.
// Insert: the search, then the shift loop moves each entry above the slot
// up through the read and write ports, and the new entry is written last.
// One request at a time; busy stays high until the response strobe.
// Reset empties the table (entry count to zero); the memory is not cleared.
`timescale 1ns / 1ps

module sorted_name_table_insert_lookup_unit #(
	parameter int CAPACITY = 64
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  sntbl_pkg::req_t req,
	output logic            done,
	output sntbl_pkg::rsp_t rsp
);
	import sntbl_pkg::*;

	localparam int IW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam logic [CW-1:0] CAP = CW'(CAPACITY);

	state_t state_q, state_d;

	logic [CW-1:0] count_q;
	logic [CW-1:0] lo_q, hi_q, mid_q, rptr_q;
	logic [IW-1:0] wdst_q;
	logic          pend_q;
	logic          hit_q;
	logic          op_q;
	logic [63:0]   key_q;
	logic [15:0]   esz_q, eof_q;
	logic [15:0]   fsz_q, fof_q;
	logic          done_q;
	rsp_t          rsp_q, rsp_d;
	logic          emit;

	logic [CW:0]   mid_sum;
	logic [CW-1:0] mid;
	logic          probe;
	logic          shift_rd;
	logic          final_wr;
	logic          accept;

	logic          we;
	logic [IW-1:0] waddr, raddr;
	entry_t        wdata, rdata;

	sntbl_ram #(.DEPTH(CAPACITY)) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign accept  = start && (state_q == S_IDLE);
	assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid     = mid_sum[CW:1];
	assign probe   = lo_q < hi_q;
	assign shift_rd = (state_q == S_SHIFT) && (rptr_q > lo_q);
	assign final_wr = (state_q == S_SHIFT) && (rptr_q == lo_q) && !pend_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		emit    = 1'b0;
		rsp_d.status     = ST_OK;
		rsp_d.found      = hit_q;
		rsp_d.slot       = 7'(lo_q);
		rsp_d.size_out   = fsz_q;
		rsp_d.offset_out = fof_q;
		raddr = mid[IW-1:0];
		we    = 1'b0;
		waddr = wdst_q;
		wdata = rdata;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					state_d = S_SEARCH;
				end
			end
			S_SEARCH: begin
				if (probe) begin
					raddr   = mid[IW-1:0];
					state_d = S_CMP;
				end else if (lo_q < count_q) begin
					raddr   = lo_q[IW-1:0];
					state_d = S_HIT;
				end else begin
					state_d = S_DECIDE;
				end
			end
			S_CMP: begin
				state_d = S_SEARCH;
			end
			S_HIT: begin
				state_d = S_DECIDE;
			end
			S_DECIDE: begin
				if (op_q == OP_LOOKUP || hit_q) begin
					rsp_d.status = (op_q == OP_LOOKUP) ? ST_OK : ST_DUP;
					emit    = 1'b1;
					state_d = S_IDLE;
				end else if (count_q == CAP) begin
					rsp_d.status = ST_FULL;
					emit    = 1'b1;
					state_d = S_IDLE;
				end else begin
					state_d = S_SHIFT;
				end
			end
			S_SHIFT: begin
				// read entry i-1 while the one read last cycle lands at i
				raddr = IW'(rptr_q - 1'b1);
				if (pend_q) begin
					we    = 1'b1;
					waddr = wdst_q;
					wdata = rdata;
				end else if (final_wr) begin
					we           = 1'b1;
					waddr        = lo_q[IW-1:0];
					wdata.key    = key_q;
					wdata.size   = esz_q;
					wdata.offset = eof_q;
					emit         = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			pend_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= emit;
			pend_q <= shift_rd;
			if (final_wr) begin
				count_q <= count_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			rsp_q <= rsp_d;
		end
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					op_q  <= req.opcode;
					key_q <= req.key;
					esz_q <= req.entry_size;
					eof_q <= req.entry_offset;
					lo_q  <= '0;
					hi_q  <= count_q;
					hit_q <= 1'b0;
					fsz_q <= '0;
					fof_q <= '0;
				end
			end
			S_SEARCH: begin
				mid_q <= mid;
			end
			S_CMP: begin
				if (rdata.key < key_q) begin
					lo_q <= mid_q + 1'b1;
				end else begin
					hi_q <= mid_q;
				end
			end
			S_HIT: begin
				hit_q <= (rdata.key == key_q);
				if (rdata.key == key_q) begin
					fsz_q <= rdata.size;
					fof_q <= rdata.offset;
				end
			end
			S_DECIDE: begin
				rptr_q <= count_q;
			end
			S_SHIFT: begin
				if (shift_rd) begin
					rptr_q <= rptr_q - 1'b1;
					wdst_q <= rptr_q[IW-1:0];
				end
			end
			default: begin
			end
		endcase
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

`ifndef ASSERT_OFF
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CAP)
		else $error("entry count above capacity");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (state_q == S_IDLE))
		else $error("response strobe while busy");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("request taken without going busy");

	a_write_shift: assert property (@(posedge clk) disable iff (!arst_n)
		we |-> (state_q == S_SHIFT))
		else $error("memory written outside the shift phase");

	a_pend_shift: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> (state_q == S_SHIFT) && (wdst_q > lo_q[IW-1:0]))
		else $error("pending move outside the shift window");
`endif

endmodule

>>> tb/sntbl_checker.sv
// Checker: predicts table responses from observed requests and compares them.
`timescale 1ns / 1ps

module sntbl_checker #(
	parameter int CAPACITY = 64
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic            busy,
	input  sntbl_pkg::req_t req,
	input  logic            done,
	input  sntbl_pkg::rsp_t rsp,
	output int              fails,
	output int              outstanding
);
	import sntbl_pkg::*;

	typedef struct {
		req_t cause;
		rsp_t want;
	} pending_rsp_t;

	logic [63:0]  tbl_key  [CAPACITY];
	logic [15:0]  tbl_size [CAPACITY];
	logic [15:0]  tbl_off  [CAPACITY];
	int           tbl_count;
	pending_rsp_t rsp_q[$];

	task automatic flag_error(input string msg);
		if (fails < 40)
			$display("[%0t] sntbl mismatch: %s", $realtime, msg);
		fails++;
	endtask

	// Slot is the number of stored keys below the request key; the table is
	// updated only by an accepted insert of a new key with room left.
	function automatic rsp_t table_apply(input req_t r);
		rsp_t res;
		int   pos;
		bit   hit;
		res = '0;
		pos = 0;
		while (pos < tbl_count && tbl_key[pos] < r.key)
			pos++;
		hit = (pos < tbl_count) && (tbl_key[pos] == r.key);
		res.status = ST_OK;
		res.found = hit;
		res.slot = pos[6:0];
		if (hit) begin
			res.size_out = tbl_size[pos];
			res.offset_out = tbl_off[pos];
		end
		if (r.opcode == OP_INSERT) begin
			if (hit) begin
				res.status = ST_DUP;
			end else if (tbl_count >= CAPACITY) begin
				res.status = ST_FULL;
			end else begin
				for (int i = tbl_count; i > pos; i--) begin
					tbl_key[i] = tbl_key[i - 1];
					tbl_size[i] = tbl_size[i - 1];
					tbl_off[i] = tbl_off[i - 1];
				end
				tbl_key[pos] = r.key;
				tbl_size[pos] = r.entry_size;
				tbl_off[pos] = r.entry_offset;
				tbl_count++;
			end
		end
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		pending_rsp_t p;
		if (!arst_n) begin
			tbl_count = 0;
			rsp_q.delete();
			fails = 0;
			outstanding = 0;
		end else begin
			// a response at this edge always belongs to an earlier request
			if (done === 1'b1) begin
				if (rsp_q.size() == 0) begin
					flag_error("response strobe with no request outstanding");
				end else begin
					p = rsp_q.pop_front();
					if (rsp.status !== p.want.status)
						flag_error($sformatf("key %h op %0b status %0d, want %0d",
							p.cause.key, p.cause.opcode, rsp.status, p.want.status));
					if (rsp.found !== p.want.found)
						flag_error($sformatf("key %h op %0b found %0b, want %0b",
							p.cause.key, p.cause.opcode, rsp.found, p.want.found));
					if (rsp.slot !== p.want.slot)
						flag_error($sformatf("key %h op %0b slot %0d, want %0d",
							p.cause.key, p.cause.opcode, rsp.slot, p.want.slot));
					if (rsp.size_out !== p.want.size_out)
						flag_error($sformatf("key %h op %0b size_out %h, want %h",
							p.cause.key, p.cause.opcode, rsp.size_out, p.want.size_out));
					if (rsp.offset_out !== p.want.offset_out)
						flag_error($sformatf("key %h op %0b offset_out %h, want %h",
							p.cause.key, p.cause.opcode, rsp.offset_out,
							p.want.offset_out));
				end
			end
			if (start === 1'b1 && busy === 1'b0) begin
				p.cause = req;
				p.want = table_apply(req);
				rsp_q.push_back(p);
			end
			outstanding = rsp_q.size();
		end
	end

endmodule

>>> tb/tb_top.sv
// Testbench top: clock, reset, request stimulus, watchdog and verdict.
`timescale 1ns / 1ps

module tb_top;
	import sntbl_pkg::*;

	localparam int CAPACITY    = 64;
	localparam int RAND_ITEMS  = 1130;
	localparam int STALL_LIMIT = 2000;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	req_t req;
	logic done;
	rsp_t rsp;
	int   fails;
	int   outstanding;
	int   quiet_cycles;

	logic [63:0] key_pool[$];

	sorted_name_table_insert_lookup_unit #(.CAPACITY(CAPACITY)) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.req   (req),
		.done  (done),
		.rsp   (rsp)
	);

	sntbl_checker #(.CAPACITY(CAPACITY)) chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.req        (req),
		.done       (done),
		.rsp        (rsp),
		.fails      (fails),
		.outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Big-endian, zero padded: first character lands in the top byte.
	function automatic logic [63:0] pack_name(input string s);
		logic [63:0] k;
		logic [7:0]  b;
		k = '0;
		for (int i = 0; i < 8; i++) begin
			b = (i < s.len()) ? s[i] : 8'h00;
			k = {k[55:0], b};
		end
		return k;
	endfunction

	function automatic req_t make_req(input logic op, input logic [63:0] k,
			input logic [15:0] sz, input logic [15:0] off);
		req_t r;
		r.opcode = op;
		r.key = k;
		r.entry_size = sz;
		r.entry_offset = off;
		return r;
	endfunction

	function automatic logic [63:0] pick_key();
		logic [63:0] k;
		logic [7:0]  b;
		int          sel;
		int          len;
		sel = $urandom_range(0, 99);
		k = '0;
		if (sel < 40 && key_pool.size() > 0) begin
			k = key_pool[$urandom_range(0, key_pool.size() - 1)];
		end else if (sel < 55 && key_pool.size() > 0) begin
			k = key_pool[$urandom_range(0, key_pool.size() - 1)];
			k = $urandom_range(0, 1) ? k + 64'd1 : k - 64'd1;
		end else if (sel < 80) begin
			len = $urandom_range(1, 8);
			for (int i = 0; i < 8; i++) begin
				b = (i < len) ? 8'(8'h61 + $urandom_range(0, 25)) : 8'h00;
				k = {k[55:0], b};
			end
		end else if (sel < 92) begin
			k = {$urandom(), $urandom()};
		end else begin
			case ($urandom_range(0, 3))
				0: k = '0;
				1: k = '1;
				2: k = 64'h8000_0000_0000_0000;
				default: k = {8'h00, 24'($urandom()), 32'($urandom())};
			endcase
		end
		return k;
	endfunction

	function automatic logic [15:0] pick_field();
		case ($urandom_range(0, 9))
			0: return 16'h0000;
			1: return 16'hFFFF;
			default: return 16'($urandom());
		endcase
	endfunction

	// start stays high across back-to-back requests; accepted when busy was low
	task automatic issue_request(input req_t r);
		start <= 1'b1;
		req <= r;
		do @(posedge clk); while (busy !== 1'b0);
		if (r.opcode == OP_INSERT)
			key_pool.push_back(r.key);
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			quiet_cycles <= 0;
		end else begin
			if ((start === 1'b1 && busy === 1'b0) || done === 1'b1)
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("** sorted_name_table_insert_lookup_unit: FAILED **");
				$finish;
			end
		end
	end

	initial begin
		int idle_pct[4];
		int phase;
		logic op;
		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		idle_pct = '{0, 46, 0, 24};
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty table, extremes, duplicates, odd byte patterns
		issue_request(make_req(OP_LOOKUP, 64'h0, 16'h0, 16'h0));
		issue_request(make_req(OP_LOOKUP, '1, 16'hFFFF, 16'hFFFF));
		issue_request(make_req(OP_INSERT, pack_name("main"), 16'h0000, 16'h0000));
		issue_request(make_req(OP_INSERT, 64'h0, 16'hFFFF, 16'hFFFF));
		issue_request(make_req(OP_INSERT, '1, 16'h1234, 16'h5678));
		issue_request(make_req(OP_INSERT, pack_name("a"), 16'h0001, 16'h8000));
		issue_request(make_req(OP_INSERT, pack_name("ab"), 16'h00AB, 16'h0AB0));
		issue_request(make_req(OP_INSERT, pack_name("abcdefgh"), 16'h5555, 16'hAAAA));
		issue_request(make_req(OP_INSERT, 64'h0041_0000_0000_0000, 16'hAAAA, 16'h5555));
		issue_request(make_req(OP_INSERT, 64'h4100_4200_0000_0000, 16'h0F0F, 16'hF0F0));
		issue_request(make_req(OP_INSERT, pack_name("ab"), 16'hDEAD, 16'hBEEF));
		issue_request(make_req(OP_INSERT, 64'h0, 16'h1111, 16'h2222));
		issue_request(make_req(OP_LOOKUP, pack_name("ab"), 16'hFFFF, 16'hFFFF));
		issue_request(make_req(OP_LOOKUP, pack_name("abc"), 16'h0, 16'h0));
		issue_request(make_req(OP_LOOKUP, 64'h0, 16'h0, 16'h0));
		issue_request(make_req(OP_LOOKUP, '1, 16'h0, 16'h0));
		issue_request(make_req(OP_INSERT, 64'h1, 16'h7FFF, 16'h8001));
		issue_request(make_req(OP_INSERT, 64'hFFFF_FFFF_FFFF_FFFE, 16'h8001, 16'h7FFF));
		issue_request(make_req(OP_LOOKUP, 64'h8000_0000_0000_0000, 16'h0, 16'h0));
		issue_request(make_req(OP_LOOKUP, pack_name("a"), 16'h0, 16'h0));
		issue_request(make_req(OP_LOOKUP, 64'h0041_0000_0000_0000, 16'h0, 16'h0));

		// random: the table fills early, then full, duplicate and lookup traffic
		for (int n = 0; n < RAND_ITEMS; n++) begin
			phase = (n * 4) / RAND_ITEMS;
			if ($urandom_range(0, 99) < idle_pct[phase]) begin
				start <= 1'b0;
				repeat ($urandom_range(1, 90)) @(posedge clk);
			end
			op = ($urandom_range(0, 99) < 30) ? OP_INSERT : OP_LOOKUP;
			issue_request(make_req(op, pick_key(), pick_field(), pick_field()));
		end
		start <= 1'b0;

		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		if (fails == 0) begin
			$display("** sorted_name_table_insert_lookup_unit: PASSED **");
		end else begin
			$display("** sorted_name_table_insert_lookup_unit: FAILED **");
		end
		$finish;
	end

endmodule
